>>> rtl/pdim_pkg.sv
// Types and constants for the push-button dimmer control machine.
package pdim_pkg;

  // Field widths
  localparam int unsigned TickW   = 16;
  localparam int unsigned LevelW  = 8;
  localparam int unsigned CmdW    = 3;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned InDataW  = 40;  // 33 bits of fields, padded to bytes
  localparam int unsigned OutDataW = 8;   // 4 bits of fields, padded to bytes

  // Fixed timing, in ticks
  localparam logic [TickW-1:0] PressDebounce   = 16'd20;
  localparam logic [TickW-1:0] ReleaseDebounce = 16'd10;
  localparam logic [TickW-1:0] IdleTicks       = 16'd512;

  // Register reset values
  localparam logic [TickW-1:0] LongPressReset = 16'd512;
  localparam logic [TickW-1:0] RepeatReset    = 16'd256;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] RegLongPress = 1'b0;
  localparam logic [CfgIdxW-1:0] RegRepeat    = 1'b1;

  // Lamp commands
  typedef enum logic [CmdW-1:0] {
    CMD_NONE   = 3'd0,
    CMD_OFF    = 3'd1,
    CMD_RECALL = 3'd2,
    CMD_UP     = 3'd3,
    CMD_DOWN   = 3'd4
  } cmd_e;

  // Button phases, one-hot
  typedef enum logic [5:0] {
    PH_RELEASED = 6'b000001,
    PH_DEBOUNCE = 6'b000010,
    PH_PRESSED  = 6'b000100,
    PH_LONGHELD = 6'b001000,
    PH_REL_DEB  = 6'b010000,
    PH_WAIT     = 6'b100000
  } phase_e;

  // Sleep phases, one-hot
  typedef enum logic [2:0] {
    SL_PROCESSING = 3'b001,
    SL_WAITING    = 3'b010,
    SL_READY      = 3'b100
  } sleep_e;

  // Machine state carried from tick to tick
  typedef struct packed {
    phase_e             phase;
    logic [TickW-1:0]   deadline;
    logic               dim_up;
    logic [LevelW-1:0]  lamp_level;
    sleep_e             sleep;
    logic [TickW-1:0]   idle_deadline;
  } state_t;

  // One tick's input fields
  typedef struct packed {
    logic [LevelW-1:0] min_level;
    logic [LevelW-1:0] actual_level;
    logic              button_up;
    logic [TickW-1:0]  now;
  } tick_t;

  // One or two commands produced by a tick
  typedef struct packed {
    logic two;
    cmd_e cmd0;
    cmd_e cmd1;
    logic sleep_ready;
  } res_t;

  // One result entry
  typedef struct packed {
    cmd_e cmd;
    logic last;
    logic sleep_ready;
  } entry_t;

  // Deadline reached: signed 16-bit difference is non-negative
  function automatic logic passed(input logic [TickW-1:0] now,
                                  input logic [TickW-1:0] t);
    logic [TickW-1:0] diff;
    diff = now - t;
    return ~diff[TickW-1];
  endfunction

endpackage

>>> rtl/pdim_step.sv
// Next-state and command logic for one tick of the dimmer machine.
module pdim_step (
  input  pdim_pkg::state_t                 state_i,
  input  pdim_pkg::tick_t                  tick_i,
  input  logic [pdim_pkg::TickW-1:0]       long_press_i,
  input  logic [pdim_pkg::TickW-1:0]       repeat_i,
  output pdim_pkg::state_t                 state_o,
  output pdim_pkg::res_t                   res_o
);

  logic                        up;
  logic                        due;
  logic [pdim_pkg::LevelW-1:0] level_new;

  assign up  = tick_i.button_up;
  assign due = pdim_pkg::passed(tick_i.now, state_i.deadline);

  // Button machine
  always_comb begin
    state_o   = state_i;
    res_o     = '{two: 1'b0, cmd0: pdim_pkg::CMD_NONE, cmd1: pdim_pkg::CMD_NONE,
                  sleep_ready: 1'b0};
    level_new = (state_i.lamp_level == '0) ? tick_i.actual_level : state_i.lamp_level;
    unique case (state_i.phase)
      pdim_pkg::PH_RELEASED: begin
        if (!up) begin
          state_o.phase    = pdim_pkg::PH_DEBOUNCE;
          state_o.deadline = tick_i.now + pdim_pkg::PressDebounce;
        end
      end
      pdim_pkg::PH_DEBOUNCE: begin
        if (up) begin
          state_o.phase = pdim_pkg::PH_RELEASED;
        end else if (due) begin
          state_o.phase      = pdim_pkg::PH_PRESSED;
          state_o.deadline   = tick_i.now + long_press_i;
          state_o.lamp_level = tick_i.actual_level;
        end
      end
      pdim_pkg::PH_PRESSED: begin
        if (up) begin
          res_o.cmd0    = (state_i.lamp_level != '0) ? pdim_pkg::CMD_OFF
                                                     : pdim_pkg::CMD_RECALL;
          state_o.phase = pdim_pkg::PH_RELEASED;
        end else if (due) begin
          // Long hold starts; a dark lamp is recalled first
          state_o.phase      = pdim_pkg::PH_LONGHELD;
          state_o.deadline   = tick_i.now + repeat_i;
          state_o.lamp_level = level_new;
          state_o.dim_up     = (level_new <= tick_i.min_level);
          if (state_i.lamp_level == '0) begin
            res_o.two  = 1'b1;
            res_o.cmd0 = pdim_pkg::CMD_RECALL;
            res_o.cmd1 = state_o.dim_up ? pdim_pkg::CMD_UP : pdim_pkg::CMD_DOWN;
          end else begin
            res_o.cmd0 = state_o.dim_up ? pdim_pkg::CMD_UP : pdim_pkg::CMD_DOWN;
          end
        end
      end
      pdim_pkg::PH_LONGHELD: begin
        if (up) begin
          state_o.phase    = pdim_pkg::PH_REL_DEB;
          state_o.deadline = tick_i.now + pdim_pkg::ReleaseDebounce;
        end else if (due) begin
          state_o.deadline = tick_i.now + repeat_i;
          res_o.cmd0 = state_i.dim_up ? pdim_pkg::CMD_UP : pdim_pkg::CMD_DOWN;
        end
      end
      pdim_pkg::PH_REL_DEB: begin
        if (due) begin
          state_o.phase    = pdim_pkg::PH_WAIT;
          state_o.deadline = tick_i.now + repeat_i;
        end
      end
      pdim_pkg::PH_WAIT: begin
        // Re-press inside the window reverses direction
        if (!up) begin
          state_o.dim_up   = ~state_i.dim_up;
          state_o.deadline = tick_i.now + repeat_i;
          state_o.phase    = pdim_pkg::PH_LONGHELD;
          res_o.cmd0 = state_i.dim_up ? pdim_pkg::CMD_DOWN : pdim_pkg::CMD_UP;
        end else if (due) begin
          state_o.phase = pdim_pkg::PH_RELEASED;
        end
      end
      default: begin
        state_o.phase = pdim_pkg::PH_RELEASED;
      end
    endcase

    // Sleep tracking, on the phase after this tick
    if (state_o.phase == pdim_pkg::PH_RELEASED) begin
      unique case (state_i.sleep)
        pdim_pkg::SL_READY: begin
          res_o.sleep_ready = 1'b1;
        end
        pdim_pkg::SL_WAITING: begin
          if (pdim_pkg::passed(tick_i.now, state_i.idle_deadline)) begin
            state_o.sleep = pdim_pkg::SL_READY;
          end
        end
        default: begin
          state_o.sleep         = pdim_pkg::SL_WAITING;
          state_o.idle_deadline = tick_i.now + pdim_pkg::IdleTicks;
        end
      endcase
    end else begin
      state_o.sleep = pdim_pkg::SL_PROCESSING;
    end
  end

endmodule

>>> rtl/pdim_out_buf.sv
// Two-entry result buffer; takes one tick's one or two results at once.
module pdim_out_buf (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  pdim_pkg::res_t res_i,
  output logic           can_push_o,
  output logic           valid_o,
  input  logic           ready_i,
  output pdim_pkg::entry_t head_o
);

  logic [1:0]       cnt_q, cnt_d;
  pdim_pkg::entry_t e0_q, e0_d, e1_q, e1_d;
  logic             pop;

  assign pop        = valid_o && ready_i;
  assign valid_o    = (cnt_q != 2'd0);
  assign head_o     = e0_q;
  // Room for two entries once this cycle's pop is done
  assign can_push_o = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && ready_i);

  // Fill and shift
  always_comb begin
    cnt_d = cnt_q;
    e0_d  = e0_q;
    e1_d  = e1_q;
    if (push_i) begin
      e0_d  = '{cmd: res_i.cmd0, last: ~res_i.two, sleep_ready: res_i.sleep_ready};
      e1_d  = '{cmd: res_i.cmd1, last: 1'b1, sleep_ready: res_i.sleep_ready};
      cnt_d = res_i.two ? 2'd2 : 2'd1;
    end else if (pop) begin
      e0_d  = e1_q;
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    e0_q <= e0_d;
    e1_q <= e1_d;
  end

endmodule

>>> rtl/pushbutton_dimmer_fsm.sv
// Top level of the push-button dimmer control machine.
//
//  channel  | dir | payload                                   | request when
//  s_axis   | in  | tdata: now, button_up, actual, min level  | tvalid & tready
//  m_axis   | out | tdata: command, sleep_ready; tlast        | tvalid & tready
//  cfg      | in  | cfg_index_i, cfg_data_i                   | cfg_valid_i & cfg_ready_o
//
// A tick request sits in the input register, is evaluated combinationally and
// lands in the two-entry result buffer; one tick per cycle when each gives
// one result and m_axis_tready is high. A tick giving two results holds back
// the next one, since the result port moves one entry per cycle. Output stalls
// back up into the input register and then s_axis_tready. Reset gives the
// released phase with the default timing registers; cfg_ready_o is always high.
module pushbutton_dimmer_fsm (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // now[15:0], button_up[16], actual_level[24:17], min_level[32:25]
  input  logic [pdim_pkg::InDataW-1:0]      s_axis_tdata,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // command[2:0], sleep_ready[3]
  output logic [pdim_pkg::OutDataW-1:0]     m_axis_tdata,
  output logic                              m_axis_tlast,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [pdim_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [pdim_pkg::TickW-1:0]        cfg_data_i
);

  logic                        in_valid_q, in_valid_d;
  pdim_pkg::tick_t             in_tick_q;
  logic                        accept, consume, can_push;
  pdim_pkg::state_t            state_q, state_d;
  pdim_pkg::res_t              res;
  pdim_pkg::entry_t            head;
  logic [pdim_pkg::TickW-1:0]  long_press_q, repeat_q;

  // Input register
  assign consume       = in_valid_q && can_push;
  assign s_axis_tready = !in_valid_q || can_push;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign in_valid_d    = accept || (in_valid_q && !consume);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_tick_q <= s_axis_tdata[$bits(pdim_pkg::tick_t)-1:0];
    end
  end

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_press_q <= pdim_pkg::LongPressReset;
      repeat_q     <= pdim_pkg::RepeatReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        pdim_pkg::RegLongPress: long_press_q <= cfg_data_i;
        pdim_pkg::RegRepeat:    repeat_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Machine state
  pdim_step u_step (
    .state_i      (state_q),
    .tick_i       (in_tick_q),
    .long_press_i (long_press_q),
    .repeat_i     (repeat_q),
    .state_o      (state_d),
    .res_o        (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{phase: pdim_pkg::PH_RELEASED, deadline: '0, dim_up: 1'b0,
                   lamp_level: '0, sleep: pdim_pkg::SL_PROCESSING,
                   idle_deadline: '0};
    end else if (consume) begin
      state_q <= state_d;
    end
  end

  // Result buffer
  pdim_out_buf u_out_buf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (consume),
    .res_i      (res),
    .can_push_o (can_push),
    .valid_o    (m_axis_tvalid),
    .ready_i    (m_axis_tready),
    .head_o     (head)
  );

  assign m_axis_tdata = {4'b0000, head.sleep_ready, head.cmd};
  assign m_axis_tlast = head.last;

endmodule
